/* sv/rank_count_despeckle_3x3_unit_assert.svh */
// assertion macros used by the checker file
`ifndef RANK_COUNT_DESPECKLE_3X3_UNIT_ASSERT_SVH
`define RANK_COUNT_DESPECKLE_3X3_UNIT_ASSERT_SVH

// same-cycle implication, quiet during reset
`define RCD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rcd check failed");

// next-cycle implication, quiet during reset
`define RCD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rcd check failed");

// condition that must hold in the cycle after reset
`define RCD_ASSERT_AFTER_RESET(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("rcd check failed");

`endif

/* sv/rcd_pkg.sv */
`default_nettype none
package rcd_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int CFG_DIM_W  = 11;
  localparam int CNT_W      = 4;
  localparam int PIX_W      = 8;
  localparam int OUT_COL_W  = 10;
  localparam int OUT_ROW_W  = 10;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;
  localparam int NB_COUNT   = 8;

  localparam logic [PIX_W-1:0]     BORDER_VALUE      = 8'd255;
  localparam logic [CFG_DIM_W-1:0] RESET_WIDTH       = 11'd1024;
  localparam logic [CFG_DIM_W-1:0] RESET_HEIGHT      = 11'd1024;
  localparam logic [CNT_W-1:0]     RESET_MIN_COUNT   = 4'd5;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_MIN_COUNT    = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } pix_t;

  typedef struct packed {
    logic [OUT_COL_W-1:0] out_col;
    logic [OUT_ROW_W-1:0] out_row;
    logic [PIX_W-1:0]     out_value;
    logic                 last;
  } res_t;

  typedef struct packed {
    logic [COL_W:0] width;
    logic [ROW_W:0] height;
    logic [CNT_W-1:0] min_count;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
  } stage_t;

  typedef struct packed {
    logic first_valid;
    res_t first;
    logic second_valid;
    res_t second;
  } pair_t;

endpackage
`default_nettype wire

/* sv/rcd_cfg.sv */
`default_nettype none
module rcd_cfg import rcd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output cfg_t              cfg
);

  logic [CFG_DIM_W-1:0] frame_width;
  logic [CFG_DIM_W-1:0] frame_height;
  logic [CNT_W-1:0]     min_count;
  logic                 wr_en;
  reg_index_t           idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RESET_WIDTH;
      frame_height <= RESET_HEIGHT;
      min_count    <= RESET_MIN_COUNT;
    end else if (wr_en) begin
      case (idx)
        REG_FRAME_WIDTH:  frame_width  <= pwdata[CFG_DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[CFG_DIM_W-1:0];
        REG_MIN_COUNT:    min_count    <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width);
      REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height);
      REG_MIN_COUNT:    prdata = DATA_W'(min_count);
      default:          prdata = '0;
    endcase
  end

  // clamp to 1..max
  always_comb begin
    if (frame_width == '0) begin
      cfg.width = (COL_W+1)'(1);
    end else if (32'(frame_width) >= 32'(MAX_WIDTH)) begin
      cfg.width = (COL_W+1)'(MAX_WIDTH);
    end else begin
      cfg.width = (COL_W+1)'(frame_width);
    end
    if (frame_height == '0) begin
      cfg.height = (ROW_W+1)'(1);
    end else if (32'(frame_height) >= 32'(MAX_HEIGHT)) begin
      cfg.height = (ROW_W+1)'(MAX_HEIGHT);
    end else begin
      cfg.height = (ROW_W+1)'(frame_height);
    end
    cfg.min_count = min_count;
  end

endmodule
`default_nettype wire

/* sv/rcd_front.sv */
`default_nettype none
module rcd_front import rcd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   pix_valid,
  output logic   pix_ready,
  input  pix_t   pix_data,
  input  logic   commit,
  output logic   stage_valid,
  output stage_t stage
);

  logic [PIX_W-1:0] upper_mem  [0:MAX_WIDTH-1];
  logic [PIX_W-1:0] middle_mem [0:MAX_WIDTH-1];

  logic [COL_W-1:0] col;
  logic [COL_W-1:0] col_next;
  logic [COL_W-1:0] c_in;
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] row_next;
  logic [ROW_W-1:0] r_in;
  logic             accept;
  logic             hit;

  assign pix_ready = !stage_valid || commit;
  assign accept    = pix_valid && pix_ready;
  assign c_in      = pix_data.frame_start ? '0 : col;
  assign r_in      = pix_data.frame_start ? '0 : row;
  // line store write of the committing item lands on the address read now
  assign hit       = commit && (stage.col == c_in);

  always_comb begin
    if (({1'b0, c_in} + (COL_W+1)'(1)) >= cfg.width) begin
      col_next = '0;
      if (({1'b0, r_in} + (ROW_W+1)'(1)) >= cfg.height) begin
        row_next = '0;
      end else begin
        row_next = r_in + ROW_W'(1);
      end
    end else begin
      col_next = c_in + COL_W'(1);
      row_next = r_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col         <= '0;
      row         <= '0;
      stage_valid <= 1'b0;
    end else begin
      if (accept) begin
        col <= col_next;
        row <= row_next;
      end
      if (accept) begin
        stage_valid <= 1'b1;
      end else if (commit) begin
        stage_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage.col <= c_in;
      stage.row <= r_in;
      stage.px  <= pix_data.pixel;
      stage.top <= hit ? stage.mid : upper_mem[c_in];
      stage.mid <= hit ? stage.px  : middle_mem[c_in];
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      upper_mem[stage.col]  <= stage.mid;
      middle_mem[stage.col] <= stage.px;
    end
  end

endmodule
`default_nettype wire

/* sv/rcd_core.sv */
`default_nettype none
module rcd_core import rcd_pkg::*; (
  input  logic   clk,
  input  cfg_t   cfg,
  input  stage_t stage,
  input  logic   commit,
  output pair_t  pair
);

  logic [PIX_W-1:0] win [0:5];
  logic [PIX_W-1:0] nb  [0:NB_COUNT-1];
  logic [PIX_W-1:0] me;
  logic [PIX_W-1:0] mx;
  logic [CNT_W-1:0] cnt;
  logic             centre_en;
  logic             border;
  res_t             centre_res;
  res_t             border_res;

  always_ff @(posedge clk) begin
    if (commit) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= stage.top;
      win[4] <= stage.mid;
      win[5] <= stage.px;
    end
  end

  assign nb[0] = win[0];
  assign nb[1] = win[1];
  assign nb[2] = win[2];
  assign nb[3] = win[3];
  assign nb[4] = win[5];
  assign nb[5] = stage.top;
  assign nb[6] = stage.mid;
  assign nb[7] = stage.px;
  assign me    = win[4];

  always_comb begin
    cnt = '0;
    mx  = '0;
    for (int i = 0; i < NB_COUNT; i++) begin
      cnt = cnt + CNT_W'(nb[i] <= me);
      if (nb[i] > mx) begin
        mx = nb[i];
      end
    end
  end

  assign centre_en = (stage.col >= COL_W'(2)) && (stage.row >= ROW_W'(2)) &&
                     ({1'b0, stage.col} < cfg.width) &&
                     ({1'b0, stage.row} < cfg.height);
  assign border    = (stage.col == '0) || (stage.row == '0) ||
                     (({1'b0, stage.col} + (COL_W+1)'(1)) >= cfg.width) ||
                     (({1'b0, stage.row} + (ROW_W+1)'(1)) >= cfg.height);

  always_comb begin
    centre_res.out_col   = OUT_COL_W'(stage.col - COL_W'(1));
    centre_res.out_row   = OUT_ROW_W'(stage.row - ROW_W'(1));
    centre_res.out_value = (cnt >= cfg.min_count) ? me : mx;
    centre_res.last      = !border;
    border_res.out_col   = OUT_COL_W'(stage.col);
    border_res.out_row   = OUT_ROW_W'(stage.row);
    border_res.out_value = BORDER_VALUE;
    border_res.last      = 1'b1;
  end

  // delayed centre goes out ahead of the arriving border pixel
  always_comb begin
    pair.first_valid  = centre_en || border;
    pair.first        = centre_en ? centre_res : border_res;
    pair.second_valid = centre_en && border;
    pair.second       = border_res;
  end

endmodule
`default_nettype wire

/* sv/rcd_out.sv */
`default_nettype none
module rcd_out import rcd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  stage_valid,
  input  pair_t pair,
  output logic  commit,
  output logic  res_valid,
  input  logic  res_ready,
  output res_t  res_data
);

  logic pend_valid;
  res_t pend_data;
  logic can_take;

  assign can_take = !res_valid || (res_ready && !pend_valid);
  assign commit   = stage_valid && can_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (commit) begin
      res_valid  <= pair.first_valid;
      pend_valid <= pair.second_valid;
    end else if (res_valid && res_ready) begin
      res_valid  <= pend_valid;
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      res_data  <= pair.first;
      pend_data <= pair.second;
    end else if (res_valid && res_ready) begin
      res_data  <= pend_data;
    end
  end

endmodule
`default_nettype wire

/* sv/rank_count_despeckle_3x3_unit.sv */
// channel   direction  handshake              payload
// pixel     in         pix_valid / pix_ready  pix_data  (pixel, frame_start)
// result    out        res_valid / res_ready  res_data  (out_col, out_row, out_value, last)
// config    in         apb write, pready = 1  paddr, pwdata / prdata
//
// one pixel per cycle unless commits are blocked; input stage, then result register
// the input stage holds the registered read of the two line stores
// a result can transfer once its pixel has passed from the input stage into the result register
// a pixel that causes two results stalls the input at least until the first of them has transferred
// a waiting result blocks commits; one more pixel can still enter the input stage
// rst clears position, valid bits and config registers; line stores need no clearing
`default_nettype none
module rank_count_despeckle_3x3_unit import rcd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              pix_valid,
  output logic              pix_ready,
  input  pix_t              pix_data,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res_data
);

  cfg_t   cfg;
  stage_t stage;
  logic   stage_valid;
  logic   commit;
  pair_t  pair;

  assign pready = 1'b1;

  rcd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  rcd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .pix_valid   (pix_valid),
    .pix_ready   (pix_ready),
    .pix_data    (pix_data),
    .commit      (commit),
    .stage_valid (stage_valid),
    .stage       (stage)
  );

  rcd_core u_core (
    .clk    (clk),
    .cfg    (cfg),
    .stage  (stage),
    .commit (commit),
    .pair   (pair)
  );

  rcd_out u_out (
    .clk         (clk),
    .rst         (rst),
    .stage_valid (stage_valid),
    .pair        (pair),
    .commit      (commit),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_data    (res_data)
  );

endmodule
`default_nettype wire

/* sv/rcd_checker.sv */
`default_nettype none
`include "rank_count_despeckle_3x3_unit_assert.svh"
module rcd_checker import rcd_pkg::*; (
  input logic clk,
  input logic rst,
  input logic res_valid,
  input logic res_ready,
  input res_t res_data
);

  // stalled result holds
  `RCD_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_data))

  // nothing comes out right after reset
  `RCD_ASSERT_AFTER_RESET(a_reset_quiet, !res_valid)

  // first column and first row are always border
  `RCD_ASSERT_NOW(a_edge_value, res_valid && (res_data.out_row == '0 || res_data.out_col == '0), res_data.out_value == BORDER_VALUE)

  // the second result of a pair follows without a gap
  `RCD_ASSERT_NEXT(a_pair_back_to_back, res_valid && res_ready && !res_data.last, res_valid)

endmodule

bind rank_count_despeckle_3x3_unit rcd_checker u_rcd_checker (.*);
`default_nettype wire

/* dv/despeckle_monitor.sv */
`timescale 1ns / 100ps
module despeckle_monitor import rcd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              pix_valid,
  input  logic              pix_ready,
  input  pix_t              pix_data,
  input  logic              res_valid,
  input  logic              res_ready,
  input  res_t              res_data,
  output int                mismatch_count,
  output int                pending
);

  logic [PIX_W-1:0] upper_row [MAX_WIDTH];
  logic [PIX_W-1:0] middle_row [MAX_WIDTH];
  logic [PIX_W-1:0] window [6];
  int unsigned      col_pos;
  int unsigned      row_pos;
  int unsigned      frame_w;
  int unsigned      frame_h;
  int unsigned      keep_count;
  res_t             expected_pixels [$];
  res_t             want;

  task automatic filter_pixel(input pix_t p);
    int unsigned      w;
    int unsigned      h;
    int unsigned      c;
    int unsigned      r;
    int unsigned      cnt;
    int               n;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] centre;
    logic [PIX_W-1:0] biggest;
    logic [PIX_W-1:0] nb [8];
    res_t             found [2];
    w = (frame_w == 0) ? 1 : (frame_w > MAX_WIDTH) ? MAX_WIDTH : frame_w;
    h = (frame_h == 0) ? 1 : (frame_h > MAX_HEIGHT) ? MAX_HEIGHT : frame_h;
    n = 0;
    if (p.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos;
    r = row_pos;
    top = upper_row[c];
    mid = middle_row[c];
    // interior centre sits one up and one left of the arriving pixel
    if (c >= 2 && r >= 2 && c < w && r < h) begin
      nb = '{window[0], window[1], window[2], window[3], window[5], top, mid, p.pixel};
      centre = window[4];
      biggest = '0;
      cnt = 0;
      foreach (nb[i]) begin
        if (nb[i] <= centre) cnt++;
        if (nb[i] > biggest) biggest = nb[i];
      end
      found[n].out_col = OUT_COL_W'(c - 1);
      found[n].out_row = OUT_ROW_W'(r - 1);
      found[n].out_value = (cnt >= keep_count) ? centre : biggest;
      found[n].last = 1'b0;
      n++;
    end
    if (c == 0 || r == 0 || c + 1 >= w || r + 1 >= h) begin
      found[n].out_col = OUT_COL_W'(c);
      found[n].out_row = OUT_ROW_W'(r);
      found[n].out_value = BORDER_VALUE;
      found[n].last = 1'b0;
      n++;
    end
    if (n > 0) found[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_pixels.push_back(found[i]);
    window[0] = window[3];
    window[1] = window[4];
    window[2] = window[5];
    window[3] = top;
    window[4] = mid;
    window[5] = p.pixel;
    upper_row[c] = mid;
    middle_row[c] = p.pixel;
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      col_pos = 0;
      row_pos = 0;
      frame_w = RESET_WIDTH;
      frame_h = RESET_HEIGHT;
      keep_count = RESET_MIN_COUNT;
      mismatch_count = 0;
      expected_pixels.delete();
    end else begin
      if (res_valid && res_ready) begin
        if (expected_pixels.size() == 0) begin
          mismatch_count++;
          $display("%0t: result col %0d row %0d value %0d last %0d with none expected",
                   $time, res_data.out_col, res_data.out_row, res_data.out_value,
                   res_data.last);
        end else begin
          want = expected_pixels.pop_front();
          if (res_data.out_col !== want.out_col || res_data.out_row !== want.out_row ||
              res_data.out_value !== want.out_value || res_data.last !== want.last) begin
            mismatch_count++;
            $display("%0t: expected col %0d row %0d value %0d last %0d, got %0d %0d %0d %0d",
                     $time, want.out_col, want.out_row, want.out_value, want.last,
                     res_data.out_col, res_data.out_row, res_data.out_value, res_data.last);
          end
        end
      end
      if (pix_valid && pix_ready) filter_pixel(pix_data);
      if (psel && penable && pwrite && pready) begin
        case (reg_index_t'(paddr[ADDR_W-1:2]))
          REG_FRAME_WIDTH:  frame_w = pwdata[CFG_DIM_W-1:0];
          REG_FRAME_HEIGHT: frame_h = pwdata[CFG_DIM_W-1:0];
          REG_MIN_COUNT:    keep_count = pwdata[CNT_W-1:0];
          default: ;
        endcase
      end
    end
    pending = expected_pixels.size();
  end

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
module tb;
  import rcd_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              pix_valid;
  logic              pix_ready;
  pix_t              pix_data;
  logic              res_valid;
  logic              res_ready;
  res_t              res_data;

  int failures;
  int outstanding;
  int cycle_count;
  int send_idle_pct;
  int stall_pct;

  rank_count_despeckle_3x3_unit DUT (.*);

  despeckle_monitor monitor (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pix_valid      (pix_valid),
    .pix_ready      (pix_ready),
    .pix_data       (pix_data),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res_data       (res_data),
    .mismatch_count (failures),
    .pending        (outstanding)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk) res_ready <= ($urandom_range(99) >= stall_pct);

  task automatic send_pixel(input pix_t p);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_valid <= 1'b0;
      @(negedge clk);
    end
    pix_valid <= 1'b1;
    pix_data <= p;
    do @(posedge clk); while (!pix_ready);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain;
    @(negedge clk);
    pix_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_frame(input int w, input int h, input int mc);
    drain();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_MIN_COUNT, mc);
  endtask

  task automatic run_phase(input int w, input int h, input int mc, input int count,
                           input int mode, input bit fresh);
    int               area;
    int               idx;
    int               style;
    logic [PIX_W-1:0] base;
    pix_t             p;
    set_frame(w, h, mc);
    case (mode)
      1:       begin send_idle_pct = 88; stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  stall_pct = 88; end
      3:       begin send_idle_pct = 23; stall_pct = 23; end
      default: begin send_idle_pct = 0;  stall_pct = 0;  end
    endcase
    area = ((w < 1) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w) *
           ((h < 1) ? 1 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h);
    style = $urandom_range(2);
    base = $urandom_range(255);
    idx = 0;
    for (int k = 0; k < count; k++) begin
      case (style)
        0: p.pixel = $urandom_range(255);
        1: p.pixel = base ^ PIX_W'($urandom_range(3));
        default: p.pixel = ($urandom_range(99) < 15) ?
                           ($urandom_range(1) ? 8'hFF : 8'h00) : base;
      endcase
      // frame restart at the top of each frame (not the first one unless fresh), plus stray restarts mid-frame
      p.frame_start = (idx == 0 && (fresh || k > 0)) || ($urandom_range(99) < 4);
      idx = p.frame_start ? 1 : idx + 1;
      if (idx >= area) idx = 0;
      send_pixel(p);
    end
  endtask

  logic [PIX_W-1:0] known_frame [20] = '{
    8'd10, 8'd20,  8'd30,  8'd0,
    8'd50, 8'd0,   8'd255, 8'd60,
    8'd70, 8'd128, 8'd128, 8'd255,
    8'd0,  8'd255, 8'd128, 8'd128,
    8'd1,  8'd254, 8'd7,   8'd200
  };

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pix_valid = 1'b0;
    pix_data = '0;
    res_ready = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // one small frame by hand, then a wrapped row with a restart partway through
    set_frame(4, 4, 5);
    foreach (known_frame[i]) send_pixel('{pixel: known_frame[i], frame_start: (i == 0 || i == 18)});

    run_phase(0, 0, 9, 6, 0, 1);
    run_phase(2, 2, 0, 12, 1, 1);
    run_phase(2047, 3, 15, 40, 0, 1);
    run_phase(1, 2047, 8, 40, 0, 1);
    run_phase(16, 6, 3, 55, 2, 1);
    // smaller frame picked up while the position is past its edge
    run_phase(5, 4, 7, 40, 3, 0);

    for (int ph = 0; ph < 16; ph++)
      run_phase(($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12),
                ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8),
                ($urandom_range(10) == 10) ? $urandom_range(10, 15) : $urandom_range(0, 9),
                $urandom_range(44, 60), ph % 4, 1);

    drain();
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/rcd_pkg.sv
sv/rcd_cfg.sv
sv/rcd_front.sv
sv/rcd_core.sv
sv/rcd_out.sv
sv/rank_count_despeckle_3x3_unit.sv
sv/rcd_checker.sv
dv/despeckle_monitor.sv
dv/tb.sv
